[rtl/csd_pkg.sv]
package csd_pkg;

  // field and register widths
  localparam int BANDS      = 4;
  localparam int SENT_REGS  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SENT3 = 3'd4;

  // arithmetic constants
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

  // datapath widths
  localparam int MAG_W  = 17;  // |re|, |im|
  localparam int XY_W   = 49;  // cordic x and y, signed, 30 fraction bits
  localparam int Z_W    = 62;  // cordic angle accumulator, signed Q60
  localparam int ZC_W   = 60;  // clamped octant angle
  localparam int F_W    = 60;  // octant angle in pi/32768 units, Q45
  localparam int A_W    = 61;  // quadrant and half-plane angle
  localparam int RND_W  = 62;  // signed angle with rounding offset

  // pipeline layout
  localparam int CORDIC_STEPS = 48;
  localparam int SQRT_STEPS   = 16;
  localparam int ST_CORDIC0   = 1;
  localparam int ST_AMP       = ST_CORDIC0 + SQRT_STEPS + 1;
  localparam int ST_CLAMP     = ST_CORDIC0 + CORDIC_STEPS + 1;
  localparam int ST_PP        = ST_CLAMP + 1;
  localparam int ST_SUM       = ST_PP + 1;
  localparam int ST_F         = ST_SUM + 1;
  localparam int ST_A1        = ST_F + 1;
  localparam int ST_A2        = ST_A1 + 1;
  localparam int ST_RND       = ST_A2 + 1;
  localparam int NST          = ST_RND + 1;

  localparam logic [ZC_W-1:0] ATAN_T0 = ZC_W'(PI_Q60 >> 2);

  // side information carried down the pipeline
  typedef struct packed {
    logic        ok;
    logic        defined;
    logic        swap;
    logic        re_neg;
    logic        im_neg;
    logic [31:0] power;
    logic [15:0] amp;
  } meta_t;

  // one result transaction
  typedef struct packed {
    logic               sample_ok;
    logic [31:0]        power;
    logic [15:0]        amplitude;
    logic signed [15:0] phase;
    logic               phase_defined;
  } result_t;

  // floor(2^k / d) by shift and subtract, elaboration only
  function automatic logic [63:0] pow2_div(input int k, input int d);
    logic [63:0] rem;
    logic [63:0] q;
    int          b;
    rem = '0;
    q   = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], (b == k)};
      if (rem >= 64'(d)) begin
        rem  = rem - 64'(d);
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in Q60: pi/4 for i = 0, else the truncated arctangent series
  function automatic logic [63:0] atan_entry(input int i);
    logic [63:0] acc;
    int          n;
    int          e;
    acc = '0;
    if (i == 0) begin
      acc = PI_Q60 >> 2;
    end else begin
      for (n = 0; n < 31; n++) begin
        e = i * (2 * n + 1);
        if (e <= 60) begin
          if (n[0]) begin
            acc = acc - pow2_div(60 - e, 2 * n + 1);
          end else begin
            acc = acc + pow2_div(60 - e, 2 * n + 1);
          end
        end
      end
    end
    return acc;
  endfunction

endpackage

[rtl/complex_sample_detector_unit.sv]
// complex sample detector
// input channel: in_valid / in_stall with in_band, in_re_part, in_im_part;
// one transaction per cycle is taken while in_stall is low.
// result channel: out_valid / out_stall with out_sample_ok, out_power,
// out_amplitude, out_phase and out_phase_defined, one result per sample.
// configuration: cfg_we with cfg_index and cfg_wdata writes the sentinel
// enable mask (index 0) and the band sentinels (indexes 1 to 4); write
// only while no sample is in flight.
// throughput is one sample per cycle while in_stall is low. from the
// accepting edge to out_valid a sample passes the capture register, a load stage,
// 48 cordic stages (one rotation each, the square root running one digit
// a stage alongside), a clamp stage, three stages for the scaling multiply,
// three for quadrant folding and rounding, and the output register.
// when the receiver stalls the result holds on the outputs and one more
// result drops into a skid register; in_stall rises only once the skid
// register is full, and the whole pipeline freezes with it.
// reset clears all valid bits, the enable mask and the sentinels.
module complex_sample_detector_unit
  import csd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_band,
  input  logic signed [15:0]    in_re_part,
  input  logic signed [15:0]    in_im_part,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_sample_ok,
  output logic [31:0]           out_power,
  output logic [15:0]           out_amplitude,
  output logic signed [15:0]    out_phase,
  output logic                  out_phase_defined,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // configuration registers
  logic [SENT_REGS-1:0] mask_r;
  logic [15:0]          sent_r [SENT_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      for (int b = 0; b < SENT_REGS; b++) begin
        sent_r[b] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MASK:  mask_r    <= cfg_wdata[SENT_REGS-1:0];
        CFG_SENT0: sent_r[0] <= cfg_wdata;
        CFG_SENT1: sent_r[1] <= cfg_wdata;
        CFG_SENT2: sent_r[2] <= cfg_wdata;
        CFG_SENT3: sent_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            skid_vld_r;
  logic            out_vld_r;
  logic            pipe_adv;
  logic [NST-1:0]  vld_r;

  assign pipe_adv = !skid_vld_r;
  assign in_stall = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  meta_t meta_r [NST];

  // capture stage: sentinel check, squares, magnitudes and octant fold
  logic [MAG_W-1:0] re_ext;
  logic [MAG_W-1:0] im_ext;
  logic [MAG_W-1:0] ax;
  logic [MAG_W-1:0] ay;
  logic             sent_hit;
  logic             ay_gt;
  logic [30:0]      prod_re_r;
  logic [30:0]      prod_im_r;
  logic [MAG_W-1:0] mx_r;
  logic [MAG_W-1:0] mn_r;
  logic [31:0]      prod_re_full;
  logic [31:0]      prod_im_full;

  always_comb begin
    re_ext       = {in_re_part[15], in_re_part};
    im_ext       = {in_im_part[15], in_im_part};
    ax           = re_ext[MAG_W-1] ? MAG_W'(-re_ext) : re_ext;
    ay           = im_ext[MAG_W-1] ? MAG_W'(-im_ext) : im_ext;
    ay_gt        = ay > ax;
    sent_hit     = (int'(in_band) < BANDS) && mask_r[in_band] &&
                   (in_re_part == sent_r[in_band]) && (in_im_part == sent_r[in_band]);
    prod_re_full = 32'(in_re_part * in_re_part);
    prod_im_full = 32'(in_im_part * in_im_part);
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      meta_r[0].ok      <= !sent_hit;
      meta_r[0].defined <= (in_re_part != '0) || (in_im_part != '0);
      meta_r[0].swap    <= ay_gt;
      meta_r[0].re_neg  <= in_re_part[15];
      meta_r[0].im_neg  <= in_im_part[15];
      meta_r[0].power   <= '0;
      meta_r[0].amp     <= '0;
      prod_re_r         <= prod_re_full[30:0];
      prod_im_r         <= prod_im_full[30:0];
      mx_r              <= ay_gt ? ay : ax;
      mn_r              <= ay_gt ? ax : ay;
    end
  end

  // power and square root root value
  logic [31:0] power_sum;
  logic [15:0] amp_val;

  assign power_sum = 32'(prod_re_r) + 32'(prod_im_r);

  // side information down the stages, power and amplitude set on the way
  for (genvar k = 1; k < NST; k++) begin : g_meta
    meta_t meta_nxt;

    always_comb begin
      meta_nxt = meta_r[k-1];
      if (k == ST_CORDIC0) begin
        meta_nxt.power = power_sum;
      end
      if (k == ST_AMP) begin
        meta_nxt.amp = amp_val;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        meta_r[k] <= meta_nxt;
      end
    end
  end

  // cordic vectoring, one rotation a stage
  logic signed [XY_W-1:0] cx_r [CORDIC_STEPS+1];
  logic signed [XY_W-1:0] cy_r [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]  cz_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      cx_r[0] <= $signed({2'b00, mx_r, 30'd0});
      cy_r[0] <= $signed({2'b00, mn_r, 30'd0});
      cz_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] T_I = Z_W'(atan_entry(i));
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [XY_W-1:0] x_nxt;
    logic signed [XY_W-1:0] y_nxt;
    logic signed [Z_W-1:0]  z_nxt;

    always_comb begin
      dx    = cy_r[i] >>> i;
      dy    = cx_r[i] >>> i;
      x_nxt = cx_r[i];
      y_nxt = cy_r[i];
      z_nxt = cz_r[i];
      // frozen once y has reached zero
      if (cy_r[i] != '0) begin
        if (!cy_r[i][XY_W-1]) begin
          x_nxt = cx_r[i] + dx;
          y_nxt = cy_r[i] - dy;
          z_nxt = cz_r[i] + T_I;
        end else begin
          x_nxt = cx_r[i] - dx;
          y_nxt = cy_r[i] + dy;
          z_nxt = cz_r[i] - T_I;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        cx_r[i+1] <= x_nxt;
        cy_r[i+1] <= y_nxt;
        cz_r[i+1] <= z_nxt;
      end
    end
  end

  // square root, one result bit a stage
  logic [31:0] sq_rem_r  [SQRT_STEPS+1];
  logic [31:0] sq_root_r [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      sq_rem_r[0]  <= power_sum;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [31:0] SQ_BIT = 32'd1 << (30 - 2 * j);
    logic [31:0] trial;
    logic [31:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      trial = sq_root_r[j] + SQ_BIT;
      if (sq_rem_r[j] >= trial) begin
        rem_nxt  = sq_rem_r[j] - trial;
        root_nxt = (sq_root_r[j] >> 1) + SQ_BIT;
      end else begin
        rem_nxt  = sq_rem_r[j];
        root_nxt = sq_root_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (pipe_adv) begin
        sq_rem_r[j+1]  <= rem_nxt;
        sq_root_r[j+1] <= root_nxt;
      end
    end
  end

  // round to nearest: remainder above the root means the upper integer
  always_comb begin
    if (sq_rem_r[SQRT_STEPS] > sq_root_r[SQRT_STEPS]) begin
      amp_val = sq_root_r[SQRT_STEPS][15:0] + 16'd1;
    end else begin
      amp_val = sq_root_r[SQRT_STEPS][15:0];
    end
  end

  // clamp the octant angle
  logic [ZC_W-1:0]        zc_r;
  logic signed [Z_W-1:0]  z_fin;

  assign z_fin = cz_r[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      if (z_fin[Z_W-1]) begin
        zc_r <= '0;
      end else if (z_fin > $signed({2'b00, ATAN_T0})) begin
        zc_r <= ATAN_T0;
      end else begin
        zc_r <= z_fin[ZC_W-1:0];
      end
    end
  end

  // scale by 1/pi: partial products, then their sums
  logic [63:0] pp_ll_r;
  logic [63:0] pp_lh_r;
  logic [59:0] pp_hl_r;
  logic [59:0] pp_hh_r;
  logic [33:0] mid_r;
  logic [61:0] hi_r;
  logic [F_W-1:0] f_r;
  logic [61:0]    f_sum;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      pp_ll_r <= 64'(zc_r[31:0]) * 64'(INV_PI_Q64[31:0]);
      pp_lh_r <= 64'(zc_r[31:0]) * 64'(INV_PI_Q64[63:32]);
      pp_hl_r <= 60'(60'(zc_r[ZC_W-1:32]) * 60'(INV_PI_Q64[31:0]));
      pp_hh_r <= 60'(60'(zc_r[ZC_W-1:32]) * 60'(INV_PI_Q64[63:32]));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      mid_r <= 34'(pp_ll_r[63:32]) + 34'(pp_lh_r[31:0]) + 34'(pp_hl_r[31:0]);
      hi_r  <= 62'(pp_hh_r) + 62'(pp_lh_r[63:32]) + 62'(pp_hl_r[59:32]);
    end
  end

  assign f_sum = hi_r + 62'(mid_r[33:32]);

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      f_r <= f_sum[F_W-1:0];
    end
  end

  // fold back to the full circle and round at the phase lsb
  logic [A_W-1:0]          a1_r;
  logic [A_W-1:0]          a2_r;
  logic signed [RND_W-1:0] rnd_r;

  always_ff @(posedge clk) begin
    if (pipe_adv) begin
      a1_r  <= meta_r[ST_A1-1].swap ? ((A_W'(1) << 59) - A_W'(f_r)) : A_W'(f_r);
      a2_r  <= meta_r[ST_A2-1].re_neg ? ((A_W'(1) << 60) - a1_r) : a1_r;
      rnd_r <= meta_r[ST_RND-1].im_neg ? $signed((RND_W'(1) << 44) - RND_W'(a2_r))
                                       : $signed(RND_W'(a2_r) + (RND_W'(1) << 44));
    end
  end

  // result from the last stage
  result_t pipe_res;
  meta_t   meta_last;

  always_comb begin
    meta_last               = meta_r[NST-1];
    pipe_res.sample_ok      = meta_last.ok;
    pipe_res.power          = meta_last.power;
    pipe_res.amplitude      = meta_last.amp;
    pipe_res.phase          = meta_last.defined ? $signed(rnd_r[60:45]) : '0;
    pipe_res.phase_defined  = meta_last.defined;
  end

  // output register with skid register
  result_t out_res_r;
  result_t skid_res_r;
  logic    out_vld_nxt;
  logic    skid_vld_nxt;
  logic    load_out_pipe;
  logic    load_out_skid;
  logic    load_skid;
  logic    take;
  logic    last;

  assign take = out_vld_r && !out_stall;
  assign last = vld_r[NST-1] && pipe_adv;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    skid_vld_nxt  = skid_vld_r;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    priority if (skid_vld_r) begin
      if (take) begin
        load_out_skid = 1'b1;
        skid_vld_nxt  = 1'b0;
      end
    end else if (last) begin
      if (!out_vld_r || take) begin
        load_out_pipe = 1'b1;
        out_vld_nxt   = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_pipe) begin
      out_res_r <= pipe_res;
    end else if (load_out_skid) begin
      out_res_r <= skid_res_r;
    end
    if (load_skid) begin
      skid_res_r <= pipe_res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_sample_ok     = out_res_r.sample_ok;
  assign out_power         = out_res_r.power;
  assign out_amplitude     = out_res_r.amplitude;
  assign out_phase         = out_res_r.phase;
  assign out_phase_defined = out_res_r.phase_defined;

endmodule
